[design/cylinder_mesh_tessellator_top_macros.svh]
// assertion macros for the cylinder mesh tessellator top level
// expects clk_i and rst_ni in the scope of use
`ifndef CYLINDER_MESH_TESSELLATOR_TOP_MACROS_SVH
`define CYLINDER_MESH_TESSELLATOR_TOP_MACROS_SVH

// same-cycle implication
`define CMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cmt_pkg.sv]
`timescale 1ns / 1ps
// shared types, register codes and constants of the cylinder mesh tessellator
// no dependencies
package cmt_pkg;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_SEGMENTS = 2'd2;
  localparam logic [1:0] CFG_RGBA     = 2'd3;

  localparam logic [1:0] ACT_BOTTOM = 2'd0;
  localparam logic [1:0] ACT_TOP    = 2'd1;
  localparam logic [1:0] ACT_SIDE   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [30:0] RADIUS_RST   = 31'd32768;
  localparam logic [30:0] LENGTH_RST   = 31'd65536;
  localparam logic [10:0] SEGMENTS_RST = 11'd16;
  localparam logic [31:0] RGBA_RST     = 32'hFFFF_FFFF;

  localparam int unsigned MAX_SEGMENTS  = 1024;
  localparam int unsigned MIN_SEGMENTS  = 3;
  localparam int unsigned ANGLE_STAGES  = 16;

  // phase divider: 32 quotient bits, PH_PER per stage
  localparam int unsigned PH_BITS   = 32;
  localparam int unsigned PH_PER    = 4;
  localparam int unsigned PH_STAGES = PH_BITS / PH_PER;

  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned DIV_STAGES = 16;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] segment;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [31:0]        colour;
    logic               last_vertex;
  } out_item_t;

  typedef struct packed {
    logic [10:0] n;
    logic [29:0] zh;
  } geom_t;

  // per-vertex sideband
  typedef struct packed {
    logic signed [31:0] z;
    logic               ring;
    logic               cap;
    logic               last;
  } vmeta_t;

  typedef struct packed {
    logic [10:0] idx;
    vmeta_t      meta;
  } vreq_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    vmeta_t             meta;
  } pos_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned k);
    logic [31:0] t;
    case (k)
      0:  t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9:  t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

[design/cmt_expand.sv]
`timescale 1ns / 1ps
// request sequencer: turns one surface request into its vertex requests
// depends on cmt_pkg
module cmt_expand (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cmt_pkg::geom_t    geom_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmt_pkg::in_item_t in_item_i,
  output logic              req_valid_o,
  output cmt_pkg::vreq_t    req_o
);

  logic        busy_q, busy_d;
  logic        side_q, side_d;
  logic        top_q, top_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [10:0] i_q, i_d;
  logic [10:0] i1_q, i1_d;

  logic        use_i1, is_top, is_ring, is_last;
  logic [10:0] seg_ext, i_sat, i_inc;
  logic [31:0] zh_ext;

  always_comb begin
    seg_ext = {1'b0, in_item_i.segment};
    i_sat   = (seg_ext >= geom_i.n) ? (geom_i.n - 11'd1) : seg_ext;
    i_inc   = i_sat + 11'd1;
  end

  // vertex order within a request
  always_comb begin
    use_i1  = 1'b0;
    is_top  = top_q;
    is_ring = 1'b1;
    is_last = 1'b0;
    if (side_q) begin
      unique case (cnt_q)
        3'd0: begin use_i1 = 1'b0; is_top = 1'b0; end
        3'd1: begin use_i1 = 1'b1; is_top = 1'b0; end
        3'd2: begin use_i1 = 1'b1; is_top = 1'b1; end
        3'd3: begin use_i1 = 1'b0; is_top = 1'b0; end
        3'd4: begin use_i1 = 1'b0; is_top = 1'b1; end
        3'd5: begin use_i1 = 1'b1; is_top = 1'b1; is_last = 1'b1; end
        default: begin use_i1 = 1'b0; is_top = 1'b0; end
      endcase
    end else begin
      unique case (cnt_q)
        3'd0: is_ring = 1'b0;
        3'd1: use_i1 = 1'b0;
        3'd2: begin use_i1 = 1'b1; is_last = 1'b1; end
        default: is_ring = 1'b0;
      endcase
    end
  end

  assign zh_ext = {2'b00, geom_i.zh};

  always_comb begin
    req_o.idx       = use_i1 ? i1_q : i_q;
    req_o.meta.z    = is_top ? $signed(zh_ext) : -$signed(zh_ext);
    req_o.meta.ring = is_ring;
    req_o.meta.cap  = is_ring && !side_q;
    req_o.meta.last = is_last;
  end

  assign req_valid_o = busy_q;
  assign in_ready_o  = !busy_q || (en_i && is_last);

  always_comb begin
    busy_d = busy_q;
    side_d = side_q;
    top_d  = top_q;
    cnt_d  = cnt_q;
    i_d    = i_q;
    i1_d   = i1_q;
    if (busy_q && en_i) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
    if (in_valid_i && in_ready_o) begin
      busy_d = (in_item_i.action != cmt_pkg::ACT_NONE);
      side_d = (in_item_i.action == cmt_pkg::ACT_SIDE);
      top_d  = (in_item_i.action == cmt_pkg::ACT_TOP);
      cnt_d  = 3'd0;
      i_d    = i_sat;
      i1_d   = (i_inc == geom_i.n) ? 11'd0 : i_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      side_q <= 1'b0;
      top_q  <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      side_q <= side_d;
      top_q  <= top_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q  <= i_d;
    i1_q <= i1_d;
  end

endmodule

[design/cmt_phase.sv]
`timescale 1ns / 1ps
// pipelined restoring divider: phase = floor(idx * 2^32 / n)
// depends on cmt_pkg
module cmt_phase (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [10:0]     n_i,
  input  logic            valid_i,
  input  cmt_pkg::vreq_t  req_i,
  output logic            valid_o,
  output logic [31:0]     phase_o,
  output cmt_pkg::vmeta_t meta_o
);

  localparam int unsigned NS = cmt_pkg::PH_STAGES;

  logic            v_q  [NS];
  logic [10:0]     r_q  [NS];
  logic [31:0]     q_q  [NS];
  cmt_pkg::vmeta_t m_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic            v_in;
    logic [10:0]     r_in, r_w;
    logic [31:0]     q_in, q_w;
    logic [11:0]     r2;
    cmt_pkg::vmeta_t m_in;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = req_i.idx;
      assign q_in = '0;
      assign m_in = req_i.meta;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
      assign q_in = q_q[s-1];
      assign m_in = m_q[s-1];
    end

    always_comb begin
      r_w = r_in;
      q_w = q_in;
      r2  = '0;
      for (int j = 0; j < int'(cmt_pkg::PH_PER); j++) begin
        r2 = {r_w, 1'b0};
        if (r2 >= {1'b0, n_i}) begin
          r_w = 11'(r2 - {1'b0, n_i});
          q_w = {q_w[30:0], 1'b1};
        end else begin
          r_w = r2[10:0];
          q_w = {q_w[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_w;
        q_q[s] <= q_w;
        m_q[s] <= m_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign phase_o = q_q[NS-1];
  assign meta_o  = m_q[NS-1];

endmodule

[design/cmt_cordic.sv]
`timescale 1ns / 1ps
// pipelined cordic, one rotation per stage, Q4.30 cosine and sine
// depends on cmt_pkg
module cmt_cordic #(
  parameter int unsigned ANGLE_STAGES = cmt_pkg::ANGLE_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       phase_i,
  input  cmt_pkg::vmeta_t   meta_i,
  output logic              valid_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o,
  output cmt_pkg::vmeta_t   meta_o
);

  logic                v_q [ANGLE_STAGES];
  logic                f_q [ANGLE_STAGES];
  logic signed [33:0]  x_q [ANGLE_STAGES];
  logic signed [33:0]  y_q [ANGLE_STAGES];
  logic signed [33:0]  a_q [ANGLE_STAGES];
  cmt_pkg::vmeta_t     m_q [ANGLE_STAGES];

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_st
    logic               v_in, f_in;
    logic signed [33:0] x_in, y_in, a_in, at;
    logic signed [33:0] x_w, y_w, a_w;
    cmt_pkg::vmeta_t    m_in;

    if (k == 0) begin : g_first
      logic [31:0] fa;
      // fold into the right half plane by flipping the half-turn bit
      assign f_in = phase_i[31] ^ phase_i[30];
      assign fa   = {phase_i[31] ^ f_in, phase_i[30:0]};
      assign a_in = 34'($signed(fa));
      assign x_in = cmt_pkg::GAIN_Q30;
      assign y_in = '0;
      assign v_in = valid_i;
      assign m_in = meta_i;
    end else begin : g_next
      assign f_in = f_q[k-1];
      assign a_in = a_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign v_in = v_q[k-1];
      assign m_in = m_q[k-1];
    end

    assign at = $signed({2'b00, cmt_pkg::atan_turn(k)});

    always_comb begin
      if (!a_in[33]) begin
        x_w = x_in - (y_in >>> k);
        y_w = y_in + (x_in >>> k);
        a_w = a_in - at;
      end else begin
        x_w = x_in + (y_in >>> k);
        y_w = y_in - (x_in >>> k);
        a_w = a_in + at;
      end
      // undo the fold on the way out
      if ((k == ANGLE_STAGES - 1) && f_in) begin
        x_w = -x_w;
        y_w = -y_w;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[k] <= f_in;
        x_q[k] <= x_w;
        y_q[k] <= y_w;
        a_q[k] <= a_w;
        m_q[k] <= m_in;
      end
    end
  end

  assign valid_o = v_q[ANGLE_STAGES-1];
  assign cos_o   = x_q[ANGLE_STAGES-1];
  assign sin_o   = y_q[ANGLE_STAGES-1];
  assign meta_o  = m_q[ANGLE_STAGES-1];

endmodule

[design/cmt_pos.sv]
`timescale 1ns / 1ps
// ring position: radius times cosine and sine, rounded and saturated to Q16.16
// depends on cmt_pkg
module cmt_pos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [30:0]        radius_i,
  input  logic               valid_i,
  input  logic signed [33:0] cos_i,
  input  logic signed [33:0] sin_i,
  input  cmt_pkg::vmeta_t    meta_i,
  output logic               valid_o,
  output cmt_pkg::pos_t      pos_o
);

  localparam logic signed [65:0] RND   = 66'sd536870912;
  localparam logic signed [65:0] S_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S_MIN = -66'sd2147483648;

  logic               v1_q;
  logic signed [65:0] px_q, py_q;
  cmt_pkg::vmeta_t    m1_q;

  logic signed [33:0] cx, sy;
  logic signed [65:0] rad, px_d, py_d, tx, ty;

  // the cap centre has no ring offset
  assign cx   = meta_i.ring ? cos_i : '0;
  assign sy   = meta_i.ring ? sin_i : '0;
  assign rad  = 66'($signed({1'b0, radius_i}));
  assign px_d = rad * 66'(cx);
  assign py_d = rad * 66'(sy);

  assign tx = (px_q + RND) >>> 30;
  assign ty = (py_q + RND) >>> 30;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q     <= px_d;
      py_q     <= py_d;
      m1_q     <= meta_i;
      pos_o.px <= sat32(tx);
      pos_o.py <= sat32(ty);
      pos_o.meta <= m1_q;
    end
  end

endmodule

[design/cmt_norm.sv]
`timescale 1ns / 1ps
// normal unit: squares, pipelined integer square root, three pipelined
// dividers and the output register; depends on cmt_pkg
module cmt_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [31:0]        rgba_i,
  input  logic               valid_i,
  input  cmt_pkg::pos_t      pos_i,
  output logic               valid_o,
  output cmt_pkg::out_item_t item_o
);

  localparam int unsigned NQ = cmt_pkg::SQ_STAGES;
  localparam int unsigned ND = cmt_pkg::DIV_STAGES;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // squares
  logic          v1_q;
  logic [63:0]   sqx_q, sqy_q, sqz_q;
  cmt_pkg::pos_t p1_q;
  logic [31:0]   ax, ay, az;

  assign ax = abs32(pos_i.px);
  assign ay = abs32(pos_i.py);
  assign az = abs32(pos_i.meta.z);

  // sum
  logic          v2_q;
  logic [63:0]   sum_q;
  cmt_pkg::pos_t p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= 64'(ax) * 64'(ay - ay + ax);
      sqy_q <= 64'(ay) * 64'(ay);
      sqz_q <= 64'(az) * 64'(az);
      p1_q  <= pos_i;
      sum_q <= sqx_q + sqy_q + sqz_q;
      p2_q  <= p1_q;
    end
  end

  // square root, one result bit per stage
  logic          sv_q [NQ];
  logic [63:0]   rv_q [NQ];
  logic [63:0]   rr_q [NQ];
  cmt_pkg::pos_t sp_q [NQ];

  for (genvar s = 0; s < NQ; s++) begin : g_sq
    logic          v_in;
    logic [63:0]   rv_in, rr_in, rv_w, rr_w, b;
    logic [64:0]   trial;
    cmt_pkg::pos_t p_in;

    if (s == 0) begin : g_first
      assign v_in  = v2_q;
      assign rv_in = sum_q;
      assign rr_in = '0;
      assign p_in  = p2_q;
    end else begin : g_next
      assign v_in  = sv_q[s-1];
      assign rv_in = rv_q[s-1];
      assign rr_in = rr_q[s-1];
      assign p_in  = sp_q[s-1];
    end

    assign b     = 64'(1) << (2 * (NQ - 1 - s));
    assign trial = {1'b0, rr_in} + {1'b0, b};

    always_comb begin
      if ({1'b0, rv_in} >= trial) begin
        rv_w = rv_in - trial[63:0];
        rr_w = (rr_in >> 1) + b;
      end else begin
        rv_w = rv_in;
        rr_w = rr_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s] <= 1'b0;
      end else if (en_i) begin
        sv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rv_q[s] <= rv_w;
        rr_q[s] <= rr_w;
        sp_q[s] <= p_in;
      end
    end
  end

  // divider setup: q = (|c| * 65536 + m) / (2m)
  logic          v3_q;
  logic [47:0]   num_q [3];
  logic [32:0]   den_q;
  logic          zero_q;
  cmt_pkg::pos_t p3_q;
  logic [31:0]   m;
  cmt_pkg::pos_t pl;

  assign m  = rr_q[NQ-1][31:0];
  assign pl = sp_q[NQ-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= sv_q[NQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= {abs32(pl.px), 16'h0000} + 48'(m);
      num_q[1] <= {abs32(pl.py), 16'h0000} + 48'(m);
      num_q[2] <= {abs32(pl.meta.z), 16'h0000} + 48'(m);
      den_q    <= {m, 1'b0};
      zero_q   <= (m == 32'd0);
      p3_q     <= pl;
    end
  end

  // three dividers, one quotient bit per stage
  logic          dv_q  [ND];
  logic [47:0]   rem_q [ND][3];
  logic [15:0]   quo_q [ND][3];
  logic [32:0]   dd_q  [ND];
  logic          dz_q  [ND];
  cmt_pkg::pos_t dp_q  [ND];

  for (genvar s = 0; s < ND; s++) begin : g_div
    logic          v_in, z_in;
    logic [47:0]   rem_in [3];
    logic [15:0]   quo_in [3];
    logic [47:0]   rem_w  [3];
    logic [15:0]   quo_w  [3];
    logic [32:0]   d_in;
    logic [47:0]   dk;
    cmt_pkg::pos_t p_in;

    if (s == 0) begin : g_first
      assign v_in = v3_q;
      assign z_in = zero_q;
      assign d_in = den_q;
      assign p_in = p3_q;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = num_q[l];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign v_in = dv_q[s-1];
      assign z_in = dz_q[s-1];
      assign d_in = dd_q[s-1];
      assign p_in = dp_q[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_in[l] = rem_q[s-1][l];
        assign quo_in[l] = quo_q[s-1][l];
      end
    end

    assign dk = 48'(d_in) << (ND - 1 - s);

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dk) begin
          rem_w[l] = rem_in[l] - dk;
          quo_w[l] = quo_in[l] | (16'd1 << (ND - 1 - s));
        end else begin
          rem_w[l] = rem_in[l];
          quo_w[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (en_i) begin
        dv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= rem_w[l];
          quo_q[s][l] <= quo_w[l];
        end
        dd_q[s] <= d_in;
        dz_q[s] <= z_in;
        dp_q[s] <= p_in;
      end
    end
  end

  function automatic logic signed [15:0] sgn_sat(input logic [15:0] q, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > 16'd32768) ? 16'sh8000 : 16'(-q);
    end else begin
      r = (q > 16'd32767) ? 16'sh7FFF : $signed(q);
    end
    return r;
  endfunction

  cmt_pkg::pos_t      pf;
  logic signed [15:0] nx, ny, nz;

  assign pf = dp_q[ND-1];

  always_comb begin
    if (pf.meta.cap) begin
      nx = '0;
      ny = '0;
      nz = pf.meta.z[31] ? 16'sh8000 : 16'sh7FFF;
    end else if (dz_q[ND-1]) begin
      nx = '0;
      ny = '0;
      nz = '0;
    end else begin
      nx = sgn_sat(quo_q[ND-1][0], pf.px[31]);
      ny = sgn_sat(quo_q[ND-1][1], pf.py[31]);
      nz = sgn_sat(quo_q[ND-1][2], pf.meta.z[31]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv_q[ND-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o.pos_x       <= pf.px;
      item_o.pos_y       <= pf.py;
      item_o.pos_z       <= pf.meta.z;
      item_o.norm_x      <= nx;
      item_o.norm_y      <= ny;
      item_o.norm_z      <= nz;
      item_o.colour      <= rgba_i;
      item_o.last_vertex <= pf.meta.last;
    end
  end

endmodule

[design/cylinder_mesh_tessellator_top.sv]
// cylinder mesh tessellator: one vertex leaves per cycle while the output is
// taken; a cap request gives three vertices, a side request six; each vertex
// passes through the phase divider, the cordic, the square root and the
// normal dividers in line
// reset loads the register defaults and empties the pipeline
`timescale 1ns / 1ps
`include "cylinder_mesh_tessellator_top_macros.svh"
module cylinder_mesh_tessellator_top #(
  parameter int unsigned ANGLE_STAGES = cmt_pkg::ANGLE_STAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmt_pkg::out_item_t out_item_o
);

  logic [30:0] radius_q;
  logic [30:0] length_q;
  logic [10:0] segs_q;
  logic [31:0] rgba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cmt_pkg::RADIUS_RST;
      length_q <= cmt_pkg::LENGTH_RST;
      segs_q   <= cmt_pkg::SEGMENTS_RST;
      rgba_q   <= cmt_pkg::RGBA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmt_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[30:0];
        cmt_pkg::CFG_LENGTH:   length_q <= cfg_data_i[30:0];
        cmt_pkg::CFG_SEGMENTS: segs_q   <= cfg_data_i[10:0];
        cmt_pkg::CFG_RGBA:     rgba_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmt_pkg::geom_t geom;

  always_comb begin
    if (32'(segs_q) < cmt_pkg::MIN_SEGMENTS) begin
      geom.n = 11'(cmt_pkg::MIN_SEGMENTS);
    end else if (32'(segs_q) > cmt_pkg::MAX_SEGMENTS) begin
      geom.n = 11'(cmt_pkg::MAX_SEGMENTS);
    end else begin
      geom.n = segs_q;
    end
    geom.zh = length_q[30:1];
  end

  // whole pipeline moves together; the output register frees on take
  logic en;
  assign en = out_ready_i || !out_valid_o;

  logic            req_valid;
  cmt_pkg::vreq_t  req;

  cmt_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .geom_i      (geom),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  logic            ph_valid;
  logic [31:0]     phase;
  cmt_pkg::vmeta_t ph_meta;

  cmt_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .n_i     (geom.n),
    .valid_i (req_valid),
    .req_i   (req),
    .valid_o (ph_valid),
    .phase_o (phase),
    .meta_o  (ph_meta)
  );

  logic               cs_valid;
  logic signed [33:0] cosv, sinv;
  cmt_pkg::vmeta_t    cs_meta;

  cmt_cordic #(
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .phase_i (phase),
    .meta_i  (ph_meta),
    .valid_o (cs_valid),
    .cos_o   (cosv),
    .sin_o   (sinv),
    .meta_o  (cs_meta)
  );

  logic          pos_valid;
  cmt_pkg::pos_t pos;

  cmt_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .radius_i (radius_q),
    .valid_i  (cs_valid),
    .cos_i    (cosv),
    .sin_i    (sinv),
    .meta_i   (cs_meta),
    .valid_o  (pos_valid),
    .pos_o    (pos)
  );

  cmt_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .rgba_i  (rgba_q),
    .valid_i (pos_valid),
    .pos_i   (pos),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  // a new request is only taken mid-sequence when the last vertex moves on
  `CMT_ASSERT_IMP(a_take_on_last, req_valid && in_ready_o, en, "request taken while busy")
  // a stalled pipeline keeps its pending vertex request
  `CMT_ASSERT_NXT(a_req_held, req_valid && !en, req_valid && $stable(req), "vertex request lost")
  // full-scale negative normal only on a vertex below the origin plane
  `CMT_ASSERT_IMP(a_neg_norm_z, out_valid_o && (out_item_o.norm_z == 16'sh8000),
                  out_item_o.pos_z[31], "negative z normal on upper vertex")

endmodule
